// ----- rtl/soi_pkg.sv -----
// soi_pkg: shared codes, widths and types for the segment/obstacle tester
// no dependencies; used by soi_if, segment_obstacle_intersect and soi_slab
`timescale 1ns / 1ps

package soi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int MODE_WIDTH      = 2;
  localparam int RADIUS_WIDTH    = 31;

  // obstacle kinds
  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_LINE   = 2'd0,
    MODE_CIRCLE = 2'd1,
    MODE_BOX    = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // per-axis slab status
  typedef struct packed {
    logic ok;       // slab does not rule the box out
    logic bounded;  // direction component nonzero
  } slab_flags_t;

endpackage

// ----- rtl/soi_if.sv -----
// soi_if: valid/ready channel interfaces for query and result items
// depends on soi_pkg
`timescale 1ns / 1ps

interface soi_query_if #(
  parameter int COORD_WIDTH = soi_pkg::COORD_WIDTH_DEF
);
  logic                                valid;
  logic                                ready;
  logic [soi_pkg::MODE_WIDTH-1:0]      mode;
  logic signed [COORD_WIDTH-1:0]       obs_ax;
  logic signed [COORD_WIDTH-1:0]       obs_ay;
  logic signed [COORD_WIDTH-1:0]       obs_bx;
  logic signed [COORD_WIDTH-1:0]       obs_by;
  logic [soi_pkg::RADIUS_WIDTH-1:0]    radius;
  logic signed [COORD_WIDTH-1:0]       seg_start_x;
  logic signed [COORD_WIDTH-1:0]       seg_start_y;
  logic signed [COORD_WIDTH-1:0]       seg_end_x;
  logic signed [COORD_WIDTH-1:0]       seg_end_y;

  modport source (
    output valid, mode, obs_ax, obs_ay, obs_bx, obs_by, radius,
           seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    input  ready
  );
  modport sink (
    input  valid, mode, obs_ax, obs_ay, obs_bx, obs_by, radius,
           seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    output ready
  );
endinterface

interface soi_result_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

// ----- rtl/segment_obstacle_intersect.sv -----
// segment_obstacle_intersect: six-stage segment vs line/circle/box hit test
// depends on soi_pkg, soi_if, soi_slab, soi_wmul
//
//   channel  dir  payload                                       handshake
//   query    in   mode, obs_ax/ay/bx/by, radius, seg_start/end  valid/ready
//   result   out  hit                                           valid/ready
//
// one item enters per cycle unless a held result stalls the pipeline; each result leaves from the sixth stage
// pipeline depth is set by the circle test: products, sums, then a 66x66 square
// split over two stages, then the final compare in the output register
// rst (synchronous) clears all stage valid bits; no clearing pass
// a stalled result freezes the whole pipeline, nothing is lost or repeated
`timescale 1ns / 1ps

module segment_obstacle_intersect #(
  parameter int COORD_WIDTH = soi_pkg::COORD_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  soi_query_if.sink  query,
  soi_result_if.source result
);

  localparam int W   = COORD_WIDTH;
  localparam int D   = W + 1;
  localparam int P   = 2 * D;
  localparam int S   = P + 1;
  localparam int RW  = soi_pkg::RADIUS_WIDTH;
  localparam int R2W = 2 * RW;
  localparam int CW  = ((S > R2W) ? S : R2W) + 1;
  localparam int XW  = ((2 * P) > (R2W + P)) ? (2 * P) : (R2W + P);

  function automatic logic signed [D-1:0] dif(input logic signed [W-1:0] x,
                                              input logic signed [W-1:0] y);
    return {x[W-1], x} - {y[W-1], y};
  endfunction

  function automatic logic signed [P-1:0] smul(input logic signed [D-1:0] x,
                                               input logic signed [D-1:0] y);
    logic signed [P-1:0] xe;
    logic signed [P-1:0] ye;
    xe = {{D{x[D-1]}}, x};
    ye = {{D{y[D-1]}}, y};
    return xe * ye;
  endfunction

  function automatic logic signed [S-1:0] sadd(input logic signed [P-1:0] x,
                                               input logic signed [P-1:0] y);
    return {x[P-1], x} + {y[P-1], y};
  endfunction

  logic en;
  logic v1, v2, v3, v4, v5, v6;

  // stall control: everything moves when the output slot frees
  assign en          = !v6 || result.ready;
  assign query.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else if (en) begin
      v1 <= query.valid; v2 <= v1; v3 <= v2;
      v4 <= v3;          v5 <= v4; v6 <= v5;
    end
  end

  // ---------------- stage 1: differences and slab setup
  logic signed [D-1:0] sl_enx_c, sl_exx_c, sl_dnx_c, sl_eny_c, sl_exy_c, sl_dny_c;
  soi_pkg::slab_flags_t sl_fx_c, sl_fy_c;
  logic signed [D-1:0] dir_x_c, dir_y_c;

  assign dir_x_c = dif(query.seg_end_x, query.seg_start_x);
  assign dir_y_c = dif(query.seg_end_y, query.seg_start_y);

  soi_slab #(.COORD_WIDTH(W)) u_slab_x (
    .lim_a(query.obs_ax), .lim_b(query.obs_bx), .start(query.seg_start_x),
    .dir(dir_x_c), .t_entry(sl_enx_c), .t_exit(sl_exx_c), .t_den(sl_dnx_c),
    .flags(sl_fx_c)
  );

  soi_slab #(.COORD_WIDTH(W)) u_slab_y (
    .lim_a(query.obs_ay), .lim_b(query.obs_by), .start(query.seg_start_y),
    .dir(dir_y_c), .t_entry(sl_eny_c), .t_exit(sl_exy_c), .t_den(sl_dny_c),
    .flags(sl_fy_c)
  );

  logic [soi_pkg::MODE_WIDTH-1:0] mode1;
  logic [RW-1:0]       r1;
  logic signed [D-1:0] nx1, ny1, dy1, v0x1, v0y1, v1x1, v1y1, mx1, my1, v2x1, v2y1;
  logic signed [D-1:0] enx1, exx1, dnx1, eny1, exy1, dny1;
  soi_pkg::slab_flags_t fx1, fy1;

  always_ff @(posedge clk) begin
    if (en) begin
      mode1 <= query.mode;
      r1    <= query.radius;
      nx1   <= dif(query.seg_start_y, query.seg_end_y);
      ny1   <= dir_x_c;
      dy1   <= dir_y_c;
      v0x1  <= dif(query.obs_ax, query.seg_start_x);
      v0y1  <= dif(query.obs_ay, query.seg_start_y);
      v1x1  <= dif(query.obs_bx, query.seg_start_x);
      v1y1  <= dif(query.obs_by, query.seg_start_y);
      mx1   <= dif(query.obs_ay, query.obs_by);
      my1   <= dif(query.obs_bx, query.obs_ax);
      v2x1  <= dif(query.obs_ax, query.seg_end_x);
      v2y1  <= dif(query.obs_ay, query.seg_end_y);
      enx1  <= sl_enx_c; exx1 <= sl_exx_c; dnx1 <= sl_dnx_c;
      eny1  <= sl_eny_c; exy1 <= sl_exy_c; dny1 <= sl_dny_c;
      fx1   <= sl_fx_c;  fy1  <= sl_fy_c;
    end
  end

  // ---------------- stage 2: products
  logic [soi_pkg::MODE_WIDTH-1:0] mode2;
  logic signed [P-1:0] l0, l1, l2, l3, l4, l5, l6, l7;
  logic signed [P-1:0] ww0, ww1, wd0, wd1, dd0, dd1, uu0, uu1, cr0, cr1;
  logic signed [P-1:0] bp0, bp1, bp2, bp3;
  logic [R2W-1:0]      r2_2;
  logic signed [D-1:0] enx2, exx2, dnx2, eny2, exy2, dny2;
  soi_pkg::slab_flags_t fx2, fy2;

  always_ff @(posedge clk) begin
    if (en) begin
      mode2 <= mode1;
      // line: straddle dot products
      l0 <= smul(v0x1, nx1); l1 <= smul(v0y1, ny1);
      l2 <= smul(v1x1, nx1); l3 <= smul(v1y1, ny1);
      l4 <= smul(v0x1, mx1); l5 <= smul(v0y1, my1);
      l6 <= smul(v2x1, mx1); l7 <= smul(v2y1, my1);
      // circle: w = centre - start, d = direction, u = centre - end
      ww0 <= smul(v0x1, v0x1); ww1 <= smul(v0y1, v0y1);
      wd0 <= smul(v0x1, ny1);  wd1 <= smul(v0y1, dy1);
      dd0 <= smul(ny1, ny1);   dd1 <= smul(dy1, dy1);
      uu0 <= smul(v2x1, v2x1); uu1 <= smul(v2y1, v2y1);
      cr0 <= smul(ny1, v0y1);  cr1 <= smul(dy1, v0x1);
      r2_2 <= R2W'(r1) * R2W'(r1);
      // box: cross-multiplied fraction compares
      bp0 <= smul(enx1, dny1); bp1 <= smul(eny1, dnx1);
      bp2 <= smul(exx1, dny1); bp3 <= smul(exy1, dnx1);
      enx2 <= enx1; exx2 <= exx1; dnx2 <= dnx1;
      eny2 <= eny1; exy2 <= exy1; dny2 <= dny1;
      fx2  <= fx1;  fy2  <= fy1;
    end
  end

  // ---------------- stage 3: sums, signs, circle region, box interval
  logic signed [S-1:0] s0_c, s1_c, s2_c, s3_c;
  logic signed [S-1:0] d2s_c, wd_c, dd_c, d2e_c, cr_c, ncr_c;
  logic [CW-1:0]       r2x_c;
  logic                line_hit_c, near_hit_c, use_cr_c;
  logic                pos0, pos1, pos2, pos3;
  logic signed [D-1:0] t0n_c, t0d_c, t1n_c, t1d_c;
  logic                bmiss_c;

  assign s0_c  = sadd(l0, l1);
  assign s1_c  = sadd(l2, l3);
  assign s2_c  = sadd(l4, l5);
  assign s3_c  = sadd(l6, l7);
  assign d2s_c = sadd(ww0, ww1);
  assign wd_c  = sadd(wd0, wd1);
  assign dd_c  = sadd(dd0, dd1);
  assign d2e_c = sadd(uu0, uu1);
  assign cr_c  = {cr0[P-1], cr0} - {cr1[P-1], cr1};
  assign ncr_c = -cr_c;
  assign r2x_c = CW'(r2_2);

  assign pos0 = !s0_c[S-1] && (s0_c != '0);
  assign pos1 = !s1_c[S-1] && (s1_c != '0);
  assign pos2 = !s2_c[S-1] && (s2_c != '0);
  assign pos3 = !s3_c[S-1] && (s3_c != '0);

  // line hit unless either pair lies strictly on one side
  assign line_hit_c = !((pos0 && pos1) || (s0_c[S-1] && s1_c[S-1]))
                   && !((pos2 && pos3) || (s2_c[S-1] && s3_c[S-1]));

  // circle: nearest point is start, end, or interior
  always_comb begin
    use_cr_c = 1'b0;
    if ((dd_c == '0) || (wd_c <= 0)) begin
      near_hit_c = (CW'(d2s_c[S-2:0]) <= r2x_c);
    end else if (wd_c >= dd_c) begin
      near_hit_c = (CW'(d2e_c[S-2:0]) <= r2x_c);
    end else begin
      near_hit_c = 1'b0;
      use_cr_c   = 1'b1;
    end
  end

  // box: latest entry and earliest exit
  always_comb begin
    bmiss_c = !fx2.ok || !fy2.ok || (!fx2.bounded && !fy2.bounded);
    if (fx2.bounded && fy2.bounded) begin
      if (bp0 <= bp1) begin
        t0n_c = eny2; t0d_c = dny2;
      end else begin
        t0n_c = enx2; t0d_c = dnx2;
      end
      if (bp2 <= bp3) begin
        t1n_c = exx2; t1d_c = dnx2;
      end else begin
        t1n_c = exy2; t1d_c = dny2;
      end
    end else if (fx2.bounded) begin
      t0n_c = enx2; t0d_c = dnx2; t1n_c = exx2; t1d_c = dnx2;
    end else begin
      t0n_c = eny2; t0d_c = dny2; t1n_c = exy2; t1d_c = dny2;
    end
  end

  logic [soi_pkg::MODE_WIDTH-1:0] mode3;
  logic                line_hit3, near_hit3, use_cr3, bmiss3;
  logic [P-1:0]        crm3;
  logic [P-1:0]        dd3;
  logic [R2W-1:0]      r2_3;
  logic signed [D-1:0] t0n3, t0d3, t1n3, t1d3;

  always_ff @(posedge clk) begin
    if (en) begin
      mode3     <= mode2;
      line_hit3 <= line_hit_c;
      near_hit3 <= near_hit_c;
      use_cr3   <= use_cr_c;
      crm3      <= cr_c[S-1] ? ncr_c[P-1:0] : cr_c[P-1:0];
      dd3       <= dd_c[P-1:0];
      r2_3      <= r2_2;
      t0n3 <= t0n_c; t0d3 <= t0d_c; t1n3 <= t1n_c; t1d3 <= t1d_c;
      bmiss3    <= bmiss_c;
    end
  end

  // ---------------- stages 4-5: wide circle products
  logic [2*P-1:0]   cr2_5;
  logic [R2W+P-1:0] r2dd_5;

  soi_wmul #(.A_WIDTH(P), .B_WIDTH(P)) u_mul_cr (
    .clk(clk), .en(en), .a(crm3), .b(crm3), .p(cr2_5)
  );

  soi_wmul #(.A_WIDTH(R2W), .B_WIDTH(P)) u_mul_rd (
    .clk(clk), .en(en), .a(r2_3), .b(dd3), .p(r2dd_5)
  );

  // stage 4: box entry range and cross products
  logic [soi_pkg::MODE_WIDTH-1:0] mode4;
  logic                line_hit4, near_hit4, use_cr4, bok4;
  logic signed [P-1:0] q0_4, q1_4;

  always_ff @(posedge clk) begin
    if (en) begin
      mode4     <= mode3;
      line_hit4 <= line_hit3;
      near_hit4 <= near_hit3;
      use_cr4   <= use_cr3;
      bok4      <= !bmiss3 && !t0n3[D-1] && (t0n3 <= t0d3);
      q0_4      <= smul(t0n3, t1d3);
      q1_4      <= smul(t1n3, t0d3);
    end
  end

  // stage 5: box entry not after exit
  logic [soi_pkg::MODE_WIDTH-1:0] mode5;
  logic line_hit5, near_hit5, use_cr5, box_hit5;

  always_ff @(posedge clk) begin
    if (en) begin
      mode5     <= mode4;
      line_hit5 <= line_hit4;
      near_hit5 <= near_hit4;
      use_cr5   <= use_cr4;
      box_hit5  <= bok4 && (q0_4 <= q1_4);
    end
  end

  // stage 6: output register, pick by obstacle kind
  logic hit_next;
  logic hit6;

  always_comb begin
    unique case (soi_pkg::mode_t'(mode5))
      soi_pkg::MODE_LINE:   hit_next = line_hit5;
      soi_pkg::MODE_CIRCLE: hit_next = use_cr5 ? (XW'(cr2_5) <= XW'(r2dd_5)) : near_hit5;
      soi_pkg::MODE_BOX:    hit_next = box_hit5;
      soi_pkg::MODE_NONE:   hit_next = 1'b0;
      default:              hit_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit6 <= hit_next;
    end
  end

  assign result.valid = v6;
  assign result.hit   = hit6;

endmodule

// ----- rtl/soi_slab.sv -----
// soi_slab: one axis of the box slab test, entry/exit fraction setup
// depends on soi_pkg
`timescale 1ns / 1ps

module soi_slab #(
  parameter int COORD_WIDTH = soi_pkg::COORD_WIDTH_DEF
) (
  input  logic signed [COORD_WIDTH-1:0] lim_a,
  input  logic signed [COORD_WIDTH-1:0] lim_b,
  input  logic signed [COORD_WIDTH-1:0] start,
  input  logic signed [COORD_WIDTH:0]   dir,
  output logic signed [COORD_WIDTH:0]   t_entry,
  output logic signed [COORD_WIDTH:0]   t_exit,
  output logic signed [COORD_WIDTH:0]   t_den,
  output soi_pkg::slab_flags_t          flags
);

  localparam int W = COORD_WIDTH;

  logic signed [W-1:0] lo;
  logic signed [W-1:0] hi;
  logic signed [W:0]   lo_s;
  logic signed [W:0]   hi_s;
  logic signed [W:0]   s_lo;
  logic signed [W:0]   s_hi;

  // order the bounds
  assign lo = (lim_a < lim_b) ? lim_a : lim_b;
  assign hi = (lim_a < lim_b) ? lim_b : lim_a;

  assign lo_s = {lo[W-1], lo} - {start[W-1], start};
  assign hi_s = {hi[W-1], hi} - {start[W-1], start};
  assign s_lo = {start[W-1], start} - {lo[W-1], lo};
  assign s_hi = {start[W-1], start} - {hi[W-1], hi};

  // entry/exit numerators over a denominator that is positive when dir is nonzero
  always_comb begin
    flags.bounded = (dir != '0);
    flags.ok      = flags.bounded || ((lo <= start) && (start <= hi));
    if (dir[W]) begin
      t_entry = s_hi;
      t_exit  = s_lo;
      t_den   = -dir;
    end else begin
      t_entry = lo_s;
      t_exit  = hi_s;
      t_den   = dir;
    end
  end

endmodule

// ----- rtl/soi_wmul.sv -----
// soi_wmul: two-stage unsigned wide multiplier built from four half products
// no package dependencies; instanced by segment_obstacle_intersect
`timescale 1ns / 1ps

module soi_wmul #(
  parameter int A_WIDTH = 66,
  parameter int B_WIDTH = 66
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [A_WIDTH-1:0]         a,
  input  logic [B_WIDTH-1:0]         b,
  output logic [A_WIDTH+B_WIDTH-1:0] p
);

  localparam int HA = A_WIDTH / 2;
  localparam int HB = B_WIDTH / 2;
  localparam int GA = A_WIDTH - HA;
  localparam int GB = B_WIDTH - HB;
  localparam int PW = A_WIDTH + B_WIDTH;

  logic [HA+HB-1:0] pp_ll;
  logic [HA+GB-1:0] pp_lh;
  logic [GA+HB-1:0] pp_hl;
  logic [GA+GB-1:0] pp_hh;

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= (HA+HB)'(a[HA-1:0]) * (HA+HB)'(b[HB-1:0]);
      pp_lh <= (HA+GB)'(a[HA-1:0]) * (HA+GB)'(b[B_WIDTH-1:HB]);
      pp_hl <= (GA+HB)'(a[A_WIDTH-1:HA]) * (GA+HB)'(b[HB-1:0]);
      pp_hh <= (GA+GB)'(a[A_WIDTH-1:HA]) * (GA+GB)'(b[B_WIDTH-1:HB]);
    end
  end

  // weighted sum
  always_ff @(posedge clk) begin
    if (en) begin
      p <= (PW'(pp_hh) << (HA + HB)) + (PW'(pp_lh) << HB)
         + (PW'(pp_hl) << HA) + PW'(pp_ll);
    end
  end

endmodule

// ----- rtl/soi_checker.sv -----
// soi_checker: port-level checks on the segment/obstacle tester
// depends on segment_obstacle_intersect (bound to it below)
`timescale 1ns / 1ps

module soi_checker (
  input logic clk,
  input logic rst,
  input logic q_valid,
  input logic q_ready,
  input logic r_valid,
  input logic r_ready,
  input logic r_hit
);

  logic [3:0] in_flight;
  logic [3:0] in_flight_next;

  // items accepted and not yet returned
  always_comb begin
    in_flight_next = in_flight;
    if (q_valid && q_ready) begin
      in_flight_next = in_flight_next + 4'd1;
    end
    if (r_valid && r_ready) begin
      in_flight_next = in_flight_next - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight_next;
    end
  end

  // no result right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !r_valid)
    else $error("result valid after reset");

  // input side stalls exactly when the output slot is held
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> (q_ready == (!r_valid || r_ready)))
    else $error("query ready does not follow output stall");

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(r_hit))
    else $error("stalled result dropped or changed");

  // no result can appear without an accepted item still in flight
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> (in_flight != 4'd0))
    else $error("result without matching item");

endmodule

bind segment_obstacle_intersect soi_checker u_soi_checker (
  .clk     (clk),
  .rst     (rst),
  .q_valid (query.valid),
  .q_ready (query.ready),
  .r_valid (result.valid),
  .r_ready (result.ready),
  .r_hit   (result.hit)
);
